@@ rtl/eight_bit_alu_with_bcd_flags_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the 8-bit ALU block
// Clocked concurrent assertions with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_ALU_WITH_BCD_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_BCD_FLAGS_ASSERT_SVH

// Property checked at every rising edge, ignored while reset is asserted
`define ALU8_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("alu8 assertion failed");

// Implication form: antecedent holds, consequent must hold in the same cycle
`define ALU8_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `ALU8_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

@@ rtl/alu8_pkg.sv @@
// ---------------------------------------------------------------------------
// alu8_pkg
// Types, operation codes and helper functions of the 8-bit ALU.
// ---------------------------------------------------------------------------
package alu8_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [3:0] {
    KIND_ADD = 4'd0,
    KIND_ADC = 4'd1,
    KIND_SUB = 4'd2,
    KIND_SBB = 4'd3,
    KIND_ANA = 4'd4,
    KIND_XRA = 4'd5,
    KIND_ORA = 4'd6,
    KIND_CMP = 4'd7,
    KIND_INR = 4'd8,
    KIND_DCR = 4'd9,
    KIND_RLC = 4'd10,
    KIND_RRC = 4'd11,
    KIND_RAL = 4'd12,
    KIND_RAR = 4'd13,
    KIND_DAA = 4'd14,
    KIND_DAD = 4'd15
  } alu8_kind_e;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LO_CORR = 8'h06;
  localparam logic [7:0] DAA_HI_CORR = 8'h60;
  localparam logic [3:0] NIBBLE_MAX  = 4'hF;
  localparam logic [3:0] BCD_MAX     = 4'd9;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 32;

  // Input payload, first member in the high bits (acc lands in bits 7:0)
  typedef struct packed {
    logic [15:0] pair_in;
    logic [15:0] hl_in;
    logic        parity_in;
    logic        zero_in;
    logic        sign_in;
    logic        aux_in;
    logic        carry_in;
    logic [7:0]  operand;
    logic [7:0]  acc;
  } alu8_in_t;

  // Result payload including the zero padding to 32 bits
  typedef struct packed {
    logic [2:0]  pad;
    logic        aux_carry;
    logic        carry;
    logic        parity;
    logic        zero;
    logic        sign;
    logic [15:0] result_word;
    logic [7:0]  result;
  } alu8_out_t;

  // Byte adder outputs
  typedef struct packed {
    logic       cy;
    logic       ac;
    logic [7:0] sum;
  } alu8_add_t;

  function automatic alu8_add_t add8(input logic [7:0] a, input logic [7:0] b,
                                     input logic c);
    logic [8:0] s;
    logic [8:0] x;
    alu8_add_t  r;
    s     = {1'b0, a} + {1'b0, b} + {8'd0, c};
    x     = s ^ {1'b0, a} ^ {1'b0, b};
    r.cy  = s[8];
    r.ac  = x[4];
    r.sum = s[7:0];
    return r;
  endfunction

  // 1 for an even number of ones
  function automatic logic even_parity(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

@@ rtl/eight_bit_alu_with_bcd_flags.sv @@
// ---------------------------------------------------------------------------
// eight_bit_alu_with_bcd_flags
// 8080-style accumulator ALU: arithmetic, logic, rotates, decimal adjust
// and the 16-bit pair add, with the full five-flag result.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* carries one operation per transfer: tuser holds
//   the operation code, tdata holds the accumulator, operand, incoming
//   flags and the two register pairs. Master stream m_axis_* returns one
//   result transfer per operation, in order.
//   Path: a transfer is taken into the input register, and its result shows
//   on m_axis when the result register loads it. Throughput: one operation
//   per cycle while m_axis_tready is high, set by the two-register pipeline
//   with a single pass of adders and muxes between them.
//   Stall: when m_axis_tready is low the result holds on the port; the
//   input register still takes one more transfer, and s_axis_tready drops
//   only when both registers are full.
//   Reset: both stage valid flags clear; no result is presented and the
//   block is ready right after reset is released.
// ---------------------------------------------------------------------------
module eight_bit_alu_with_bcd_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Operation input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // acc[7:0] operand[15:8] carry_in[16] aux_in[17] sign_in[18] zero_in[19]
  // parity_in[20] hl_in[36:21] pair_in[52:37] zero[55:53]
  input  logic [55:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]  s_axis_tuser,
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result[7:0] result_word[23:8] sign[24] zero[25] parity[26] carry[27]
  // aux_carry[28] zero[31:29]
  output logic [31:0] m_axis_tdata
);

  logic                 in_vld_q;
  logic [55:0]          in_data_q;
  logic [3:0]           in_kind_q;
  logic                 out_vld_q;
  alu8_pkg::alu8_out_t  out_q;
  alu8_pkg::alu8_out_t  out_d;
  logic                 out_adv;
  logic                 in_take;

  // Pipeline handshake
  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Input and result payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
      in_kind_q <= s_axis_tuser;
    end
    if (out_adv && in_vld_q) begin
      out_q <= out_d;
    end
  end

  // ALU datapath
  always_comb begin
    alu8_pkg::alu8_in_t   i;
    alu8_pkg::alu8_kind_e kind;
    alu8_pkg::alu8_add_t  ar;
    logic [7:0]           res;
    logic [7:0]           flag_src;
    logic [7:0]           corr;
    logic [16:0]          wsum;
    logic [3:0]           lo;
    logic [3:0]           hi;
    logic                 cy;
    logic                 ac;
    logic                 szp;
    logic                 carry_sel;

    i         = alu8_pkg::alu8_in_t'(in_data_q[52:0]);
    kind      = alu8_pkg::alu8_kind_e'(in_kind_q);
    lo        = i.acc[3:0];
    hi        = i.acc[7:4];
    res       = i.acc;
    flag_src  = i.acc;
    cy        = i.carry_in;
    ac        = i.aux_in;
    szp       = 1'b1;
    corr      = 8'd0;
    carry_sel = 1'b0;
    ar        = '0;
    wsum      = {1'b0, i.hl_in} + {1'b0, i.pair_in};
    out_d     = '0;

    unique case (kind)
      alu8_pkg::KIND_ADD, alu8_pkg::KIND_ADC: begin
        carry_sel = (kind == alu8_pkg::KIND_ADC) && i.carry_in;
        ar        = alu8_pkg::add8(i.acc, i.operand, carry_sel);
        res       = ar.sum;
        flag_src  = ar.sum;
        cy        = ar.cy;
        ac        = ar.ac;
      end
      alu8_pkg::KIND_SUB, alu8_pkg::KIND_SBB, alu8_pkg::KIND_CMP: begin
        // Add of the inverted operand with the inverted borrow
        carry_sel = (kind == alu8_pkg::KIND_SBB) ? !i.carry_in : 1'b1;
        ar        = alu8_pkg::add8(i.acc, ~i.operand, carry_sel);
        res       = (kind == alu8_pkg::KIND_CMP) ? i.acc : ar.sum;
        flag_src  = ar.sum;
        cy        = !ar.cy;
        ac        = ar.ac;
      end
      alu8_pkg::KIND_ANA: begin
        res      = i.acc & i.operand;
        flag_src = res;
        ac       = i.acc[3] | i.operand[3];
        cy       = 1'b0;
      end
      alu8_pkg::KIND_XRA: begin
        res      = i.acc ^ i.operand;
        flag_src = res;
        ac       = 1'b0;
        cy       = 1'b0;
      end
      alu8_pkg::KIND_ORA: begin
        res      = i.acc | i.operand;
        flag_src = res;
        ac       = 1'b0;
        cy       = 1'b0;
      end
      alu8_pkg::KIND_INR: begin
        res      = i.acc + 8'd1;
        flag_src = res;
        ac       = (res[3:0] == 4'd0);
      end
      alu8_pkg::KIND_DCR: begin
        res      = i.acc - 8'd1;
        flag_src = res;
        ac       = (res[3:0] != alu8_pkg::NIBBLE_MAX);
      end
      alu8_pkg::KIND_RLC: begin
        res = {i.acc[6:0], i.acc[7]};
        cy  = i.acc[7];
        szp = 1'b0;
      end
      alu8_pkg::KIND_RRC: begin
        res = {i.acc[0], i.acc[7:1]};
        cy  = i.acc[0];
        szp = 1'b0;
      end
      alu8_pkg::KIND_RAL: begin
        res = {i.acc[6:0], i.carry_in};
        cy  = i.acc[7];
        szp = 1'b0;
      end
      alu8_pkg::KIND_RAR: begin
        res = {i.carry_in, i.acc[7:1]};
        cy  = i.acc[0];
        szp = 1'b0;
      end
      alu8_pkg::KIND_DAA: begin
        if (i.aux_in || (lo > alu8_pkg::BCD_MAX)) begin
          corr = corr | alu8_pkg::DAA_LO_CORR;
        end
        if (i.carry_in || (hi > alu8_pkg::BCD_MAX) ||
            ((hi >= alu8_pkg::BCD_MAX) && (lo > alu8_pkg::BCD_MAX))) begin
          corr = corr | alu8_pkg::DAA_HI_CORR;
          cy   = 1'b1;
        end
        ar       = alu8_pkg::add8(i.acc, corr, 1'b0);
        res      = ar.sum;
        flag_src = ar.sum;
        ac       = ar.ac;
      end
      alu8_pkg::KIND_DAD: begin
        out_d.result_word = wsum[15:0];
        cy                = wsum[16];
        szp               = 1'b0;
      end
      default: begin
        res = i.acc;
      end
    endcase

    out_d.result    = res;
    out_d.carry     = cy;
    out_d.aux_carry = ac;
    if (szp) begin
      out_d.sign   = flag_src[7];
      out_d.zero   = (flag_src == 8'd0);
      out_d.parity = alu8_pkg::even_parity(flag_src);
    end else begin
      out_d.sign   = i.sign_in;
      out_d.zero   = i.zero_in;
      out_d.parity = i.parity_in;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/alu8_chk.sv @@
// ---------------------------------------------------------------------------
// alu8_chk
// Port-level checker for the 8-bit ALU, bound to the top level.
// ---------------------------------------------------------------------------
`include "eight_bit_alu_with_bcd_flags_assert.svh"

module alu8_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic out_stall;

  // Result offered but not taken
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Stalled result holds
  `ALU8_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

  // Input side only stalls when the output is full and blocked
  `ALU8_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // Every accepted transfer is followed by a valid result on the port
  `ALU8_ASSERT(a_latency, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)

endmodule

bind eight_bit_alu_with_bcd_flags alu8_chk u_alu8_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// tb: stream testbench for eight_bit_alu_with_bcd_flags
// Sends directed and random ALU operations over s_axis with random valid
// gaps, predicts each result and flag set, and checks m_axis transfers in
// order under random ready stalls.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned RANDOM_OPS   = 1200;
  localparam int unsigned TAIL_OPS     = 100;   // no idling once this few are left
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 1000;

  // One operation waiting to go out on s_axis
  typedef struct packed {
    alu8_pkg::alu8_kind_e kind;
    alu8_pkg::alu8_in_t   fields;
  } alu_op_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;   // see alu8_in_t, zero-padded to 56 bits
  logic [3:0]  s_axis_tuser  = '0;   // kind[3:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [31:0] m_axis_tdata;         // see alu8_out_t

  alu_op_t              ops_to_send[$];
  alu8_pkg::alu8_out_t  results_due[$];
  int unsigned          err_count   = 0;
  int unsigned          send_gap    = 0;
  int unsigned          recv_gap    = 0;
  int unsigned          idle_cycles = 0;

  eight_bit_alu_with_bcd_flags DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte add: {carry out, carry out of bit 3, sum}
  function automatic logic [9:0] byte_add(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin);
    logic [8:0] total;
    logic [8:0] toggles;
    total   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    toggles = total ^ {1'b0, a} ^ {1'b0, b};
    return {total[8], toggles[4], total[7:0]};
  endfunction

  // Expected result and flags of one operation
  function automatic alu8_pkg::alu8_out_t alu_result(input alu8_pkg::alu8_kind_e k,
                                                     input alu8_pkg::alu8_in_t x);
    alu8_pkg::alu8_out_t r;
    logic [9:0]          t;
    logic [16:0]         wide;
    logic [7:0]          flag_src;
    logic [7:0]          fix;
    logic                cy_new;
    logic                set_szp;
    r           = '0;
    r.result    = x.acc;
    r.sign      = x.sign_in;
    r.zero      = x.zero_in;
    r.parity    = x.parity_in;
    r.carry     = x.carry_in;
    r.aux_carry = x.aux_in;
    set_szp     = 1'b1;
    flag_src    = '0;
    case (k)
      alu8_pkg::KIND_ADD, alu8_pkg::KIND_ADC: begin
        t = byte_add(x.acc, x.operand, (k == alu8_pkg::KIND_ADC) ? x.carry_in : 1'b0);
        r.result    = t[7:0];
        r.aux_carry = t[8];
        r.carry     = t[9];
      end
      // subtract as add of the inverted operand, borrow is the inverted carry
      alu8_pkg::KIND_SUB, alu8_pkg::KIND_SBB, alu8_pkg::KIND_CMP: begin
        t = byte_add(x.acc, ~x.operand, (k == alu8_pkg::KIND_SBB) ? ~x.carry_in : 1'b1);
        r.result    = t[7:0];
        r.aux_carry = t[8];
        r.carry     = ~t[9];
      end
      alu8_pkg::KIND_ANA: begin
        r.result    = x.acc & x.operand;
        r.aux_carry = x.acc[3] | x.operand[3];
        r.carry     = 1'b0;
      end
      alu8_pkg::KIND_XRA: begin
        r.result    = x.acc ^ x.operand;
        r.aux_carry = 1'b0;
        r.carry     = 1'b0;
      end
      alu8_pkg::KIND_ORA: begin
        r.result    = x.acc | x.operand;
        r.aux_carry = 1'b0;
        r.carry     = 1'b0;
      end
      alu8_pkg::KIND_INR: begin
        r.result    = x.acc + 8'd1;
        r.aux_carry = (r.result[3:0] == 4'h0);
      end
      alu8_pkg::KIND_DCR: begin
        r.result    = x.acc - 8'd1;
        r.aux_carry = (r.result[3:0] != alu8_pkg::NIBBLE_MAX);
      end
      // rotates touch only the carry
      alu8_pkg::KIND_RLC: begin
        r.result = {x.acc[6:0], x.acc[7]};
        r.carry  = x.acc[7];
        set_szp  = 1'b0;
      end
      alu8_pkg::KIND_RRC: begin
        r.result = {x.acc[0], x.acc[7:1]};
        r.carry  = x.acc[0];
        set_szp  = 1'b0;
      end
      alu8_pkg::KIND_RAL: begin
        r.result = {x.acc[6:0], x.carry_in};
        r.carry  = x.acc[7];
        set_szp  = 1'b0;
      end
      alu8_pkg::KIND_RAR: begin
        r.result = {x.carry_in, x.acc[7:1]};
        r.carry  = x.acc[0];
        set_szp  = 1'b0;
      end
      alu8_pkg::KIND_DAA: begin
        fix    = '0;
        cy_new = x.carry_in;
        if (x.aux_in || x.acc[3:0] > alu8_pkg::BCD_MAX) fix = fix + alu8_pkg::DAA_LO_CORR;
        if (x.carry_in || x.acc[7:4] > alu8_pkg::BCD_MAX ||
            (x.acc[7:4] >= alu8_pkg::BCD_MAX && x.acc[3:0] > alu8_pkg::BCD_MAX)) begin
          fix    = fix + alu8_pkg::DAA_HI_CORR;
          cy_new = 1'b1;
        end
        t = byte_add(x.acc, fix, 1'b0);
        r.result    = t[7:0];
        r.aux_carry = t[8];
        r.carry     = cy_new;
      end
      default: begin
        wide          = {1'b0, x.hl_in} + {1'b0, x.pair_in};
        r.result_word = wide[15:0];
        r.carry       = wide[16];
        set_szp       = 1'b0;
      end
    endcase
    // compare leaves acc alone but flags follow the difference
    flag_src = r.result;
    if (k == alu8_pkg::KIND_CMP) r.result = x.acc;
    if (set_szp) begin
      r.sign   = flag_src[7];
      r.zero   = (flag_src == 8'h00);
      r.parity = ~(^flag_src);
    end
    return r;
  endfunction

  // Byte with a bias toward edge and BCD values
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  // Queue one operation; fields not given are random
  task automatic queue_op(input alu8_pkg::alu8_kind_e k, input logic [7:0] a,
                          input logic [7:0] b, input logic cy, input logic ac);
    alu_op_t op;
    op.kind             = k;
    op.fields           = alu8_pkg::alu8_in_t'(53'({$urandom, $urandom}));
    op.fields.acc       = a;
    op.fields.operand   = b;
    op.fields.carry_in  = cy;
    op.fields.aux_in    = ac;
    ops_to_send.push_back(op);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Driver: present queued operations, random valid gaps, predict on transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        results_due.push_back(alu_result(alu8_pkg::alu8_kind_e'(s_axis_tuser),
                                         alu8_pkg::alu8_in_t'(s_axis_tdata[52:0])));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (ops_to_send.size() > TAIL_OPS && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          alu_op_t op;
          op = ops_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= op.kind;
          s_axis_tdata  <= {3'b000, op.fields};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stall bursts until the tail of the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (ops_to_send.size() > TAIL_OPS && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    alu8_pkg::alu8_out_t got;
    alu8_pkg::alu8_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = alu8_pkg::alu8_out_t'(m_axis_tdata);
      if (results_due.size() == 0) begin
        $display("%0t: result %h with none expected", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = results_due.pop_front();
        check_field("result",      16'(want.result),    16'(got.result));
        check_field("result_word", want.result_word,    got.result_word);
        check_field("sign",        16'(want.sign),      16'(got.sign));
        check_field("zero",        16'(want.zero),      16'(got.zero));
        check_field("parity",      16'(want.parity),    16'(got.parity));
        check_field("carry",       16'(want.carry),     16'(got.carry));
        check_field("aux_carry",   16'(want.aux_carry), 16'(got.aux_carry));
        check_field("padding",     16'(want.pad),       16'(got.pad));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    alu8_pkg::alu8_kind_e k;
    // directed: edges of each operation
    queue_op(alu8_pkg::KIND_ADD, 8'hFF, 8'h01, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_ADC, 8'hFF, 8'hFF, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_ADD, 8'h7F, 8'h01, 1'b0, 1'b1);
    queue_op(alu8_pkg::KIND_SUB, 8'h00, 8'h01, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_SBB, 8'h00, 8'hFF, 1'b1, 1'b1);
    queue_op(alu8_pkg::KIND_SBB, 8'h80, 8'h00, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_ANA, 8'h08, 8'h00, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_ANA, 8'hF7, 8'hF7, 1'b1, 1'b1);
    queue_op(alu8_pkg::KIND_XRA, 8'hFF, 8'hFF, 1'b1, 1'b1);
    queue_op(alu8_pkg::KIND_ORA, 8'h00, 8'h00, 1'b1, 1'b1);
    queue_op(alu8_pkg::KIND_CMP, 8'h5A, 8'h5A, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_CMP, 8'h01, 8'hFF, 1'b0, 1'b1);
    queue_op(alu8_pkg::KIND_INR, 8'hFF, 8'h00, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_INR, 8'h0F, 8'h00, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_DCR, 8'h00, 8'h00, 1'b0, 1'b1);
    queue_op(alu8_pkg::KIND_DCR, 8'h10, 8'h00, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_RLC, 8'h80, 8'h00, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_RRC, 8'h01, 8'h00, 1'b0, 1'b1);
    queue_op(alu8_pkg::KIND_RAL, 8'h80, 8'h00, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_RAR, 8'h01, 8'h00, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_DAA, 8'h9A, 8'h00, 1'b0, 1'b0);
    queue_op(alu8_pkg::KIND_DAA, 8'h99, 8'h00, 1'b0, 1'b1);
    queue_op(alu8_pkg::KIND_DAA, 8'h00, 8'h00, 1'b1, 1'b0);
    queue_op(alu8_pkg::KIND_DAD, 8'h12, 8'h34, 1'b0, 1'b1);
    ops_to_send[$].fields.hl_in   = 16'hFFFF;
    ops_to_send[$].fields.pair_in = 16'h0001;
    queue_op(alu8_pkg::KIND_DAD, 8'h00, 8'hFF, 1'b1, 1'b0);
    ops_to_send[$].fields.hl_in   = 16'h0000;
    ops_to_send[$].fields.pair_in = 16'h0000;

    // random operations
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      k = alu8_pkg::alu8_kind_e'($urandom_range(0, 15));
      queue_op(k, pick_byte(), pick_byte(), 1'($urandom), 1'($urandom));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ops_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
